// ----- sv/dpx_pkg.sv -----
// shared types, format codes and pixel conversion functions for the pixel converter
package dpx_pkg;

  // frame format register codes
  localparam logic [1:0] FMT_RGB888  = 2'd0;
  localparam logic [1:0] FMT_RGB565  = 2'd1;
  localparam logic [1:0] FMT_FLOAT   = 2'd2;
  localparam logic [1:0] FMT_UNSUPP  = 2'd3;

  // ieee single fields
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_ONE      = 8'd127;
  localparam logic [7:0] EXP_HALF     = 8'd126;
  // exponents below this give a zero channel; the smallest exponent that can round up to one is 118
  localparam logic [7:0] EXP_MIN_LUMA = 8'd110;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  // 5-bit channel to 8 bits by copying the high bits into the low bits
  function automatic chan_t widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // 6-bit channel to 8 bits
  function automatic chan_t widen6(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction

  // floor(clamp(v,0,1) * 255 + 1/2) from the bits of an ieee single
  function automatic chan_t luma_from_float(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [31:0] prod;
    logic [7:0]  down_shift;
    logic [8:0]  trunc;
    logic [9:0]  rounded;
    chan_t       res;
    sign = bits[31];
    expo = bits[30:23];
    frac = bits[22:0];
    // mantissa times 255 as a shift and subtract, always below 2^32
    prod = {1'b1, frac, 8'd0} - {8'd0, 1'b1, frac};
    down_shift = EXP_HALF - expo;
    // keep one bit below the rounding point, then add a half and drop it
    trunc = prod[31:23] >> down_shift[4:0];
    rounded = {1'b0, trunc} + 10'd1;
    if (expo == EXP_ALL_ONES && frac != '0) begin
      res = '0;
    end else if (sign) begin
      res = '0;
    end else if (expo >= EXP_ONE) begin
      res = 8'hFF;
    end else if (expo < EXP_MIN_LUMA) begin
      res = '0;
    end else begin
      res = rounded[8:1];
    end
    return res;
  endfunction

endpackage

// ----- sv/display_pixel_to_rgb888_unit.sv -----
// top level: display pixel word to rgb888 converter with input and result registers
//
// Converts one raw display pixel word per clock into a 24-bit RGB pixel, as
// chosen by the frame format register: rgb888 pass-through, rgb565 widened by
// bit replication, or a float luminance clamped to [0,1], scaled by 255 and
// rounded half up, sent to all three channels. The unsupported format raises
// tuser and gives zero channels. A word passes through an input register, then
// the result register, and one word is taken every clock while the output
// side keeps tready high. The format register may be written only while no
// word is in flight.
module display_pixel_to_rgb888_unit
  import dpx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // frame_format
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_word
  input  logic        s_axis_tlast,  // last_pixel
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tuser,  // bad_format
  output logic        m_axis_tlast   // last_out
);

  logic [1:0]  frame_format;
  logic        in_valid;
  logic [31:0] in_word;
  logic        in_last;
  logic        out_adv;
  logic        in_adv;
  rgb_t        rgb_next;
  logic        bad_next;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format <= FMT_RGB888;
    end else if (cfg_wr_en) begin
      frame_format <= cfg_wr_data;
    end
  end

  // stage handshakes
  assign out_adv       = !m_axis_tvalid || m_axis_tready;
  assign in_adv        = !in_valid || out_adv;
  assign s_axis_tready = in_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && s_axis_tvalid) begin
      in_word <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // format conversion
  always_comb begin
    rgb_next = '0;
    bad_next = 1'b0;
    case (frame_format)
      FMT_RGB888: begin
        rgb_next.red   = in_word[7:0];
        rgb_next.green = in_word[15:8];
        rgb_next.blue  = in_word[23:16];
      end
      FMT_RGB565: begin
        rgb_next.red   = widen5(in_word[15:11]);
        rgb_next.green = widen6(in_word[10:5]);
        rgb_next.blue  = widen5(in_word[4:0]);
      end
      FMT_FLOAT: begin
        rgb_next.red   = luma_from_float(in_word);
        rgb_next.green = rgb_next.red;
        rgb_next.blue  = rgb_next.red;
      end
      default: begin
        bad_next = 1'b1;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      m_axis_tdata <= rgb_next;
      m_axis_tuser <= bad_next;
      m_axis_tlast <= in_last;
    end
  end

endmodule

// ----- sv/dpx_checker.sv -----
// port checker for the pixel converter and its bind to the top level
module dpx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [1:0] words_held;
  logic       s_acc;
  logic       m_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      words_held <= '0;
    end else begin
      words_held <= words_held + {1'b0, s_acc} - {1'b0, m_acc};
    end
  end

  // a bad format word carries zero channels
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad format word with nonzero channels");

  // no word shows up that was never accepted
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> words_held != 2'd0)
    else $error("result word without an accepted input");

  // at most two words in flight
  assert property (@(posedge clk) disable iff (rst)
    words_held != 2'd3)
    else $error("more words in flight than stages");

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result word changed");

endmodule

bind display_pixel_to_rgb888_unit dpx_checker u_dpx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
